FILE: hdl/bds_pkg.sv
package bds_pkg;

  // number format
  localparam int FRAC_BITS  = 8;
  localparam int PRES_FRAC  = 16;
  localparam int COORD_W    = 20;
  localparam int PRES_W     = 17;
  localparam int DIA_W      = 20;
  localparam int RATE_W     = 16;
  localparam int TRAV_W     = 24;
  localparam int DPF_W      = PRES_W + FRAC_BITS - PRES_FRAC;

  // segment arithmetic
  localparam int SQ_W       = 42;
  localparam int LEN_W      = SQ_W / 2;
  localparam int SPC_W      = 28;
  localparam int SPC_SHIFT  = 25;
  localparam int HS_SHIFT   = 17;
  localparam int MUL_A_W    = PRES_W + DIA_W;
  localparam int MUL_B_W    = LEN_W;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int DVD_W      = SPC_W + LEN_W;
  localparam int DVS_W      = SPC_W + 1;
  localparam int TEST_W     = DVD_W + 1;

  localparam int MAX_DABS_DEF = 64;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_DIAMETER     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING_RATE = 1'b1;
  localparam logic [DIA_W-1:0]     DIA_RESET        = 20'd2560;
  localparam logic [RATE_W-1:0]    RATE_RESET       = 16'd256;

  // opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_MOVE  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SQ    = 12'b000000000010,
    S_ROOT  = 12'b000000000100,
    S_SP    = 12'b000000001000,
    S_SPAT  = 12'b000000010000,
    S_DDIV  = 12'b000000100000,
    S_TEST  = 12'b000001000000,
    S_INT   = 12'b000010000000,
    S_HS    = 12'b000100000000,
    S_PUSH  = 12'b001000000000,
    S_FLUSH = 12'b010000000000,
    S_FIN   = 12'b100000000000
  } state_t;

endpackage

FILE: hdl/bds_sqrt.sv
// Integer square root, one result bit per cycle (restoring, two radicand bits a step).
module bds_sqrt #(
  parameter int RAD_W = bds_pkg::SQ_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [RAD_W-1:0]     radicand,
  output logic                 done,
  output logic [RAD_W/2-1:0]   root
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]   rad_r;
  logic [ROOT_W:0]    rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [ROOT_W+2:0]  r4;
  logic [ROOT_W+2:0]  trial;
  logic               ge;

  assign r4    = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = (r4 >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (ge) begin
        rem_r  <= ROOT_W'(r4 - trial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= r4[ROOT_W:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("sqrt restarted while busy");

endmodule

FILE: hdl/bds_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module bds_div #(
  parameter int DVD_W = bds_pkg::DVD_W,
  parameter int DVS_W = bds_pkg::DVS_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   sh;
  logic             ge;

  assign sh = {rem_r, quo_r[DVD_W-1]};
  assign ge = (sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= DVS_W'(sh - {1'b0, dvs_r});
      end else begin
        rem_r <= sh[DVS_W-1:0];
      end
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");

endmodule

FILE: hdl/brush_dab_spacing.sv
// brush_dab_spacing: places brush dabs along a pen stroke.
// Input channel (in_valid / in_stall): one transaction per stroke point with an
// opcode (start, move, move-and-end). Output channel (out_valid / out_stall):
// one transaction per dab: center, half size, last_dab on the final dab of a
// point, overflow on that dab when dabs past MAX_DABS were dropped.
// Config: cfg_we writes diameter (index 0) or spacing_rate (index 1); write only
// while idle.
// Flow: one point at a time; in_stall is high while a move or end point of an
// active stroke is worked on, until it is fully done. A start or ignored
// point is handled in idle and never raises in_stall. A move point first
// computes its length (sum of squares, then square root) and the spacing
// setup, then each dab needs up to four passes through the shared 49-bit
// bit-serial divider (spacing step, then p, x, y interpolation).
// One dab is held back so the last one can be flagged; a dab waits in the
// output register while out_stall is high, and the walk pauses when both the
// output register and the hold slot are full.
// Reset (synchronous, rst_n low): no stroke, previous point and travelled
// distance zero, diameter 10.0, spacing_rate 1.0, output empty.
module brush_dab_spacing #(
  parameter int MAX_DABS = bds_pkg::MAX_DABS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bds_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_opcode,
  input  logic [bds_pkg::COORD_W-1:0]       in_point_x,
  input  logic [bds_pkg::COORD_W-1:0]       in_point_y,
  input  logic [bds_pkg::PRES_W-1:0]        in_pressure,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bds_pkg::COORD_W-1:0]       out_center_x,
  output logic [bds_pkg::COORD_W-1:0]       out_center_y,
  output logic [bds_pkg::COORD_W-1:0]       out_half_size,
  output logic                              out_last_dab,
  output logic                              out_overflow
);

  localparam int CW    = bds_pkg::COORD_W;
  localparam int PW    = bds_pkg::PRES_W;
  localparam int LW    = bds_pkg::LEN_W;
  localparam int SW    = bds_pkg::SPC_W;
  localparam int TW    = bds_pkg::TRAV_W;
  localparam int AW    = bds_pkg::MUL_A_W;
  localparam int BW    = bds_pkg::MUL_B_W;
  localparam int PRW   = bds_pkg::MUL_P_W;
  localparam int DVD_W = bds_pkg::DVD_W;
  localparam int DVS_W = bds_pkg::DVS_W;
  localparam int TSW   = bds_pkg::TEST_W;
  localparam int CNT_W = $clog2(MAX_DABS + 1);
  localparam logic [SW-1:0] HALF = SW'(1 << (bds_pkg::FRAC_BITS - 1));
  localparam logic [TW-1:0] TRAV_MAX = '1;

  // interpolation axis
  localparam logic [1:0] AX_P = 2'd0;
  localparam logic [1:0] AX_X = 2'd1;
  localparam logic [1:0] AX_Y = 2'd2;

  bds_pkg::state_t st_r;
  logic [2:0]      ph_r;

  // configuration and stroke state
  logic [bds_pkg::DIA_W-1:0]  dia_r;
  logic [bds_pkg::RATE_W-1:0] rate_r;
  logic                       active_r;
  logic [CW-1:0]              px_r, py_r;
  logic [PW-1:0]              pp_r;
  logic [TW-1:0]              trav_r;

  // current point
  logic [1:0]    op_r;
  logic [CW-1:0] x1_r, y1_r;
  logic [PW-1:0] p1_r;

  // walk state
  logic [bds_pkg::SQ_W-1:0] sq_r;
  logic [LW-1:0]            len_r;
  logic [SW-1:0]            sp1_r;
  logic signed [SW:0]       dsall_r;
  logic [LW-1:0]            at_r;
  logic [PW-1:0]            pat_r;
  logic [TW-1:0]            acc_r;
  logic [DVS_W-1:0]         den_r;
  logic [TSW-1:0]           test_r;
  logic [CNT_W-1:0]         n_r;
  logic                     ovf_r;
  logic [1:0]               ax_r;
  logic [CW-1:0]            new_cx_r, new_cy_r, new_hs_r;
  logic [PW-1:0]            new_pt_r;

  // held dab and output register
  logic          pend_v_r;
  logic [CW-1:0] pend_cx_r, pend_cy_r, pend_hs_r;
  logic          out_v_r;
  logic [CW-1:0] out_cx_r, out_cy_r, out_hs_r;
  logic          out_last_r, out_ovf_r;

  logic in_acc;
  logic out_free;
  assign in_stall = (st_r != bds_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_v_r || !out_stall;

  // segment deltas (sign and magnitude)
  logic [CW:0]   dx_w, dy_w;
  logic [PW:0]   dp_w;
  logic [CW-1:0] dxm, dym;
  logic [PW-1:0] dpm;
  logic [PW+bds_pkg::FRAC_BITS-1:0] dp_sh;
  logic [bds_pkg::DPF_W-1:0]        dpf;

  assign dx_w  = {1'b0, x1_r} - {1'b0, px_r};
  assign dy_w  = {1'b0, y1_r} - {1'b0, py_r};
  assign dp_w  = {1'b0, p1_r} - {1'b0, pp_r};
  assign dxm   = dx_w[CW] ? CW'(-dx_w) : dx_w[CW-1:0];
  assign dym   = dy_w[CW] ? CW'(-dy_w) : dy_w[CW-1:0];
  assign dpm   = dp_w[PW] ? PW'(-dp_w) : dp_w[PW-1:0];
  assign dp_sh = {dpm, {bds_pkg::FRAC_BITS{1'b0}}};
  assign dpf   = dp_sh[PW+bds_pkg::FRAC_BITS-1:bds_pkg::PRES_FRAC];

  // shared multiplier, product registered
  logic [AW-1:0]  mul_a;
  logic [BW-1:0]  mul_b;
  logic [PRW-1:0] mul_p_r;
  logic [SW-1:0]  spc_w;

  always_ff @(posedge clk) begin
    mul_p_r <= PRW'(mul_a) * PRW'(mul_b);
  end

  assign spc_w = mul_p_r[bds_pkg::SPC_SHIFT+SW-1:bds_pkg::SPC_SHIFT];

  // spacing step evaluation
  logic               s_lo;
  logic [SW-1:0]      s_eff;
  logic signed [SW:0] ds_eff;
  logic signed [SW+1:0] den_w;
  logic signed [SW:0] num_w;
  logic               den_pos, num_pos;

  assign s_lo    = (spc_w < HALF);
  assign s_eff   = s_lo ? HALF : spc_w;
  assign ds_eff  = s_lo ? '0 : dsall_r;
  assign den_w   = $signed({{(SW+2-LW){1'b0}}, len_r}) - $signed({ds_eff[SW], ds_eff});
  assign num_w   = $signed({1'b0, s_eff}) - $signed({{(SW+1-TW){1'b0}}, acc_r});
  assign den_pos = !den_w[SW+1] && (den_w != '0);
  assign num_pos = !num_w[SW] && (num_w != '0);

  // travelled distance at the end of a segment, saturating
  logic [TW:0]   acc_sum;
  logic [TW-1:0] acc_end;
  assign acc_sum = {1'b0, acc_r} + (TW+1)'(len_r - at_r);
  assign acc_end = acc_sum[TW] ? TRAV_MAX : acc_sum[TW-1:0];

  // interpolation axis select
  logic [CW-1:0] ax_mag, ax_base;
  logic          ax_neg;
  always_comb begin
    unique case (ax_r)
      AX_X: begin
        ax_mag  = dxm;
        ax_base = px_r;
        ax_neg  = dx_w[CW];
      end
      AX_Y: begin
        ax_mag  = dym;
        ax_base = py_r;
        ax_neg  = dy_w[CW];
      end
      default: begin
        ax_mag  = CW'(dpm);
        ax_base = CW'(pp_r);
        ax_neg  = dp_w[PW];
      end
    endcase
  end

  // iterative units
  logic             sq_start, sq_done;
  logic [LW-1:0]    sq_root;
  logic             div_start, div_done;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs;
  logic [CW:0]      ax_res;

  assign sq_start = (st_r == bds_pkg::S_SQ) && (ph_r == 3'd4);
  assign ax_res   = ax_neg ? ({1'b0, ax_base} - (CW+1)'(div_q))
                           : ({1'b0, ax_base} + (CW+1)'(div_q));

  bds_sqrt #(.RAD_W(bds_pkg::SQ_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  bds_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // operand steering
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = mul_p_r[DVD_W-1:0];
    div_dvs   = den_r;
    unique case (st_r)
      bds_pkg::S_SQ: begin
        unique case (ph_r)
          3'd0: begin
            mul_a = AW'(dxm);
            mul_b = BW'(dxm);
          end
          3'd1: begin
            mul_a = AW'(dym);
            mul_b = BW'(dym);
          end
          3'd2: begin
            mul_a = AW'(dpf);
            mul_b = BW'(dpf);
          end
          default: ;
        endcase
      end
      bds_pkg::S_SP: begin
        unique case (ph_r)
          3'd0: begin
            mul_a = AW'(p1_r);
            mul_b = BW'(dia_r);
          end
          3'd1, 3'd3: begin
            mul_a = mul_p_r[AW-1:0];
            mul_b = BW'(rate_r);
          end
          3'd2: begin
            mul_a = AW'(pp_r);
            mul_b = BW'(dia_r);
          end
          default: ;
        endcase
      end
      bds_pkg::S_SPAT: begin
        unique case (ph_r)
          3'd0: begin
            mul_a = AW'(pat_r);
            mul_b = BW'(dia_r);
          end
          3'd1: begin
            mul_a = mul_p_r[AW-1:0];
            mul_b = BW'(rate_r);
          end
          3'd2: begin
            mul_a = AW'(num_w[SW-1:0]);
            mul_b = BW'(len_r);
          end
          3'd3: div_start = 1'b1;
          default: ;
        endcase
      end
      bds_pkg::S_INT: begin
        if (ph_r == 3'd0) begin
          mul_a = AW'(ax_mag);
          mul_b = test_r[BW-1:0];
        end else if (ph_r == 3'd1) begin
          div_start = 1'b1;
          div_dvs   = DVS_W'(len_r);
        end
      end
      bds_pkg::S_HS: begin
        mul_a = AW'(new_pt_r);
        mul_b = BW'(dia_r);
      end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dia_r  <= bds_pkg::DIA_RESET;
      rate_r <= bds_pkg::RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bds_pkg::REG_DIAMETER:     dia_r  <= cfg_wdata[bds_pkg::DIA_W-1:0];
        bds_pkg::REG_SPACING_RATE: rate_r <= cfg_wdata[bds_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= bds_pkg::S_IDLE;
      ph_r     <= '0;
      active_r <= 1'b0;
      px_r     <= '0;
      py_r     <= '0;
      pp_r     <= '0;
      trav_r   <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      n_r      <= '0;
      ovf_r    <= 1'b0;
      ax_r     <= AX_P;
    end else begin
      if (!out_stall) begin
        out_v_r <= 1'b0;
      end
      unique case (st_r)
        bds_pkg::S_IDLE: begin
          if (in_acc) begin
            op_r  <= in_opcode;
            x1_r  <= in_point_x;
            y1_r  <= in_point_y;
            p1_r  <= in_pressure;
            acc_r <= trav_r;
            ph_r  <= '0;
            if (in_opcode == bds_pkg::OP_START) begin
              active_r <= 1'b1;
              px_r     <= in_point_x;
              py_r     <= in_point_y;
              pp_r     <= in_pressure;
              trav_r   <= '0;
            end else if (active_r && (in_opcode == bds_pkg::OP_MOVE ||
                                      in_opcode == bds_pkg::OP_END)) begin
              st_r <= bds_pkg::S_SQ;
            end
          end
        end
        bds_pkg::S_SQ: begin
          ph_r <= ph_r + 1'b1;
          if (ph_r == 3'd1) sq_r <= mul_p_r[bds_pkg::SQ_W-1:0];
          if (ph_r == 3'd2 || ph_r == 3'd3) begin
            sq_r <= sq_r + mul_p_r[bds_pkg::SQ_W-1:0];
          end
          if (ph_r == 3'd4) st_r <= bds_pkg::S_ROOT;
        end
        bds_pkg::S_ROOT: begin
          if (sq_done) begin
            len_r <= sq_root;
            ph_r  <= '0;
            st_r  <= (sq_root == '0) ? bds_pkg::S_FIN : bds_pkg::S_SP;
          end
        end
        bds_pkg::S_SP: begin
          ph_r <= ph_r + 1'b1;
          if (ph_r == 3'd2) sp1_r <= spc_w;
          if (ph_r == 3'd4) begin
            dsall_r <= $signed({1'b0, sp1_r}) - $signed({1'b0, spc_w});
            at_r    <= '0;
            n_r     <= '0;
            ovf_r   <= 1'b0;
            pat_r   <= pp_r;
            ph_r    <= '0;
            st_r    <= bds_pkg::S_SPAT;
          end
        end
        bds_pkg::S_SPAT: begin
          ph_r <= ph_r + 1'b1;
          if (ph_r == 3'd2) begin
            if (!den_pos) begin
              acc_r <= acc_end;
              st_r  <= bds_pkg::S_FLUSH;
            end else if (num_pos) begin
              den_r <= den_w[DVS_W-1:0];
            end else begin
              test_r <= TSW'(at_r);
              st_r   <= bds_pkg::S_TEST;
            end
          end
          if (ph_r == 3'd3) st_r <= bds_pkg::S_DDIV;
        end
        bds_pkg::S_DDIV: begin
          if (div_done) begin
            test_r <= TSW'(at_r) + ((div_q == '0) ? TSW'(1) : TSW'(div_q));
            st_r   <= bds_pkg::S_TEST;
          end
        end
        bds_pkg::S_TEST: begin
          ph_r <= '0;
          ax_r <= AX_P;
          if (test_r < TSW'(len_r)) begin
            if (n_r >= CNT_W'(MAX_DABS)) begin
              ovf_r <= 1'b1;
              acc_r <= '0;
              st_r  <= bds_pkg::S_FLUSH;
            end else begin
              st_r <= bds_pkg::S_INT;
            end
          end else begin
            acc_r <= acc_end;
            st_r  <= bds_pkg::S_FLUSH;
          end
        end
        bds_pkg::S_INT: begin
          if (ph_r != 3'd2) begin
            ph_r <= ph_r + 1'b1;
          end else if (div_done) begin
            ph_r <= '0;
            unique case (ax_r)
              AX_X: new_cx_r <= ax_res[CW-1:0];
              AX_Y: new_cy_r <= ax_res[CW-1:0];
              default: new_pt_r <= ax_res[PW-1:0];
            endcase
            if (ax_r == AX_Y) begin
              st_r <= bds_pkg::S_HS;
            end else begin
              ax_r <= ax_r + 1'b1;
            end
          end
        end
        bds_pkg::S_HS: begin
          ph_r <= ph_r + 1'b1;
          if (ph_r != 3'd0) begin
            new_hs_r <= mul_p_r[bds_pkg::HS_SHIFT+CW-1:bds_pkg::HS_SHIFT];
            st_r     <= bds_pkg::S_PUSH;
          end
        end
        bds_pkg::S_PUSH: begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_v_r    <= 1'b1;
              out_cx_r   <= pend_cx_r;
              out_cy_r   <= pend_cy_r;
              out_hs_r   <= pend_hs_r;
              out_last_r <= 1'b0;
              out_ovf_r  <= 1'b0;
            end
            pend_v_r  <= 1'b1;
            pend_cx_r <= new_cx_r;
            pend_cy_r <= new_cy_r;
            pend_hs_r <= new_hs_r;
            n_r       <= n_r + 1'b1;
            acc_r     <= '0;
            at_r      <= test_r[LW-1:0];
            pat_r     <= new_pt_r;
            ph_r      <= '0;
            st_r      <= bds_pkg::S_SPAT;
          end
        end
        bds_pkg::S_FLUSH: begin
          if (!pend_v_r) begin
            st_r <= bds_pkg::S_FIN;
          end else if (out_free) begin
            out_v_r    <= 1'b1;
            out_cx_r   <= pend_cx_r;
            out_cy_r   <= pend_cy_r;
            out_hs_r   <= pend_hs_r;
            out_last_r <= 1'b1;
            out_ovf_r  <= ovf_r;
            pend_v_r   <= 1'b0;
            st_r       <= bds_pkg::S_FIN;
          end
        end
        bds_pkg::S_FIN: begin
          px_r   <= x1_r;
          py_r   <= y1_r;
          pp_r   <= p1_r;
          trav_r <= acc_r;
          if (op_r == bds_pkg::OP_END) active_r <= 1'b0;
          st_r   <= bds_pkg::S_IDLE;
        end
        default: st_r <= bds_pkg::S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_v_r;
  assign out_center_x  = out_cx_r;
  assign out_center_y  = out_cy_r;
  assign out_half_size = out_hs_r;
  assign out_last_dab  = out_last_r;
  assign out_overflow  = out_ovf_r;

  a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == bds_pkg::S_IDLE |-> !pend_v_r)
    else $error("held dab left over after point finished");

  a_dab_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_DABS)) else $error("dab count past limit");

  a_ovf_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_ovf_r |-> out_last_r)
    else $error("overflow flagged on a dab that is not the last");

  a_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == bds_pkg::S_PUSH && pend_v_r && out_free |=> pend_v_r && out_v_r)
    else $error("held dab lost on push");

endmodule
